### rtl/csds_pkg.sv
// shared types and constants of the c-scan disk scheduler
`timescale 1ns / 1ps

package csds_pkg;

    // fixed field widths
    localparam int CYL_W     = 16;
    localparam int DISK_W    = 17;
    localparam int MOVE_W    = 18;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_CYL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_CYL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_UP  = 2'd2;

    // one request
    typedef struct packed {
        logic [CYL_W-1:0] cylinder;
        logic             last_request;
    } csds_req_t;

    // one scheduled result
    typedef struct packed {
        logic [CYL_W-1:0]  served_cylinder;
        logic              last_served;
        logic [MOVE_W-1:0] total_movement;
    } csds_res_t;

    // geometry taken when a batch closes
    typedef struct packed {
        logic [CYL_W-1:0] top;
        logic [CYL_W-1:0] head;
        logic             sweep_up;
    } csds_sched_t;

    // one request picked by the scan unit
    typedef struct packed {
        logic             valid;
        logic [CYL_W-1:0] value;
        logic             last;
        logic             wrapped;
    } csds_emit_t;

endpackage

### rtl/csds_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module csds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/csds_scan.sv
// selection scan: one pass over the request store per served request
`timescale 1ns / 1ps

module csds_scan
    import csds_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    localparam int IDX_W = $clog2(QUEUE_DEPTH),
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [CNT_W-1:0] n,
    input  csds_sched_t      sched,
    output logic             rd_en,
    output logic [IDX_W-1:0] rd_addr,
    input  logic [CYL_W-1:0] rd_data,
    output csds_emit_t       emit
);

    localparam int KEY_W = 1 + CYL_W + IDX_W;

    logic             run_reg;
    logic [IDX_W-1:0] addr_reg;
    logic             rv_reg;
    logic [IDX_W-1:0] ridx_reg;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] emit_cnt_reg;
    logic             prev_valid_reg;
    logic [KEY_W-1:0] prev_key_reg;
    logic             best_valid_reg;
    logic [KEY_W-1:0] best_key_reg;
    logic [CYL_W-1:0] best_val_reg;
    logic             emit_valid_reg;
    logic [CYL_W-1:0] emit_val_reg;
    logic             emit_last_reg;
    logic             emit_wrap_reg;

    logic [CNT_W-1:0] n_m1;
    logic [IDX_W-1:0] last_idx;
    logic [CYL_W-1:0] v;
    logic             grp;
    logic [CYL_W-1:0] kval;
    logic [KEY_W-1:0] key;
    logic             take;
    logic             mrg_valid;
    logic [KEY_W-1:0] mrg_key;
    logic [CYL_W-1:0] mrg_val;
    logic             pass_end;
    logic             final_emit;

    // key of the returning entry: service group, then position in sweep order, then slot
    always_comb
    begin
        n_m1     = n_reg - CNT_W'(1);
        last_idx = n_m1[IDX_W-1:0];
        v        = (rd_data > sched.top) ? sched.top : rd_data;
        grp      = sched.sweep_up ? (v < sched.head) : (v > sched.head);
        kval     = sched.sweep_up ? v : ~v;
        key      = {grp, kval, ridx_reg};
    end

    // smallest key above the one served last
    always_comb
    begin
        take       = rv_reg && (!prev_valid_reg || key > prev_key_reg)
                            && (!best_valid_reg || key < best_key_reg);
        mrg_valid  = best_valid_reg || take;
        mrg_key    = take ? key : best_key_reg;
        mrg_val    = take ? v : best_val_reg;
        pass_end   = rv_reg && (ridx_reg == last_idx);
        final_emit = pass_end && (emit_cnt_reg == n_m1);
    end

    // pass sequencing and best tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg        <= 1'b0;
            rv_reg         <= 1'b0;
            prev_valid_reg <= 1'b0;
            best_valid_reg <= 1'b0;
            emit_valid_reg <= 1'b0;
            emit_cnt_reg   <= '0;
        end
        else
        begin
            emit_valid_reg <= 1'b0;
            if (go)
            begin
                run_reg        <= 1'b1;
                addr_reg       <= '0;
                rv_reg         <= 1'b0;
                prev_valid_reg <= 1'b0;
                best_valid_reg <= 1'b0;
                emit_cnt_reg   <= '0;
                n_reg          <= n;
            end
            else if (run_reg)
            begin
                addr_reg <= (addr_reg == last_idx) ? '0 : addr_reg + IDX_W'(1);
                rv_reg   <= 1'b1;
                ridx_reg <= addr_reg;
                if (take)
                begin
                    best_valid_reg <= 1'b1;
                    best_key_reg   <= key;
                    best_val_reg   <= v;
                end
                if (pass_end)
                begin
                    emit_valid_reg <= 1'b1;
                    emit_val_reg   <= mrg_val;
                    emit_last_reg  <= final_emit;
                    emit_wrap_reg  <= mrg_key[KEY_W-1];
                    prev_valid_reg <= 1'b1;
                    prev_key_reg   <= mrg_key;
                    best_valid_reg <= 1'b0;
                    emit_cnt_reg   <= emit_cnt_reg + CNT_W'(1);
                    if (final_emit)
                    begin
                        run_reg <= 1'b0;
                        rv_reg  <= 1'b0;
                    end
                end
            end
        end
    end

    assign rd_en   = run_reg;
    assign rd_addr = addr_reg;
    assign emit    = '{valid: emit_valid_reg, value: emit_val_reg,
                       last: emit_last_reg, wrapped: emit_wrap_reg};

`ifndef NO_ASSERTIONS
    // never more picks than stored requests
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> emit_cnt_reg < n_reg)
        else $error("scan emitted too many requests");

    // every pass finds an unserved request
    a_pass_found: assert property (@(posedge clk) disable iff (!rst_n)
        pass_end |-> mrg_valid)
        else $error("scan pass ended without a candidate");

    // picks only come out of a running scan
    a_emit_run: assert property (@(posedge clk) disable iff (!rst_n)
        emit_valid_reg |-> $past(run_reg))
        else $error("emit without running scan");
`endif

endmodule

### rtl/cscan_disk_scheduler_core.sv
// top level of the c-scan disk scheduler: config, request store, output stage
`timescale 1ns / 1ps

// Usage
// Requests come in on req with a start pulse; a transfer happens on a cycle with
// start high and busy low. Non-final requests are written into the request store,
// one per cycle, while it holds fewer than QUEUE_DEPTH entries, and busy stays
// low. A request with last_request closes the batch (it is stored too unless the
// store already holds QUEUE_DEPTH entries). After the closing transfer busy goes
// high and the store is scanned: each pass reads all n stored entries through the
// single ram read port and picks the next cylinder in c-scan order, so one result
// leaves per pass over the store. Each result is on result for one cycle, marked
// by result_valid; the receiver cannot stall. The last result carries last_served
// and the total head movement. busy drops as the last result goes out.
// Configuration writes use cfg_valid, cfg_ready (always high), cfg_index and
// cfg_data; the user must see that they are taken between batches, as the block
// does not enforce it. Reset restores start cylinder 0, 65536 cylinders, upward
// sweep, empty store.
module cscan_disk_scheduler_core
    import csds_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  csds_req_t            req,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DISK_W-1:0]    cfg_data,
    output logic                 result_valid,
    output csds_res_t            result
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CYL_W-1:0]  start_cyl_reg;
    logic [DISK_W-1:0] disk_cyl_reg;
    logic              sweep_up_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              busy_reg;
    csds_sched_t       sched_reg;
    logic [MOVE_W-1:0] base_reg;
    logic              result_valid_reg;
    csds_res_t         result_reg;

    logic              accept;
    logic              close;
    logic              full;
    logic              wr_en;
    logic [CNT_W-1:0]  n_close;
    logic [CYL_W-1:0]  top_c;
    logic [CYL_W-1:0]  head_c;
    logic [MOVE_W-1:0] base_next;
    logic [MOVE_W-1:0] extra;
    logic [MOVE_W-1:0] total;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [CYL_W-1:0]  rd_data;
    csds_emit_t        emit;

    // request transfer and store fill
    always_comb
    begin
        accept  = start && !busy_reg;
        close   = accept && req.last_request;
        full    = (count_reg == CNT_W'(QUEUE_DEPTH));
        wr_en   = accept && !full;
        n_close = full ? count_reg : count_reg + CNT_W'(1);
    end

    // disk geometry with out-of-range sizes and head folded in
    always_comb
    begin
        if (disk_cyl_reg == '0)
        begin
            top_c = '0;
        end
        else if (disk_cyl_reg[DISK_W-1])
        begin
            top_c = '1;
        end
        else
        begin
            top_c = disk_cyl_reg[CYL_W-1:0] - CYL_W'(1);
        end
        head_c = (start_cyl_reg > top_c) ? top_c : start_cyl_reg;
    end

    // movement up to the wrap point: run to the end plus the jump
    always_comb
    begin
        if (sched_reg.sweep_up)
        begin
            base_next = (MOVE_W'(sched_reg.top) << 1) - MOVE_W'(sched_reg.head);
        end
        else
        begin
            base_next = MOVE_W'(sched_reg.head) + MOVE_W'(sched_reg.top);
        end
    end

    // travel in the wrapped group ends at the last served cylinder
    always_comb
    begin
        if (!emit.wrapped)
        begin
            extra = '0;
        end
        else if (sched_reg.sweep_up)
        begin
            extra = MOVE_W'(emit.value);
        end
        else
        begin
            extra = MOVE_W'(sched_reg.top - emit.value);
        end
        total = base_reg + extra;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_cyl_reg <= '0;
            disk_cyl_reg  <= DISK_W'(65536);
            sweep_up_reg  <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_START_CYL: start_cyl_reg <= cfg_data[CYL_W-1:0];
                CFG_DISK_CYL:  disk_cyl_reg  <= cfg_data;
                CFG_SWEEP_UP:  sweep_up_reg  <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // batch control and output strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            busy_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= emit.valid;
            if (close)
            begin
                count_reg <= '0;
                busy_reg  <= 1'b1;
            end
            else if (wr_en)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (emit.valid && emit.last)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // geometry snapshot, movement base and result payload
    always_ff @(posedge clk)
    begin
        if (close)
        begin
            sched_reg <= '{top: top_c, head: head_c, sweep_up: sweep_up_reg};
        end
        base_reg <= base_next;
        if (emit.valid)
        begin
            result_reg.served_cylinder <= emit.value;
            result_reg.last_served     <= emit.last;
            result_reg.total_movement  <= emit.last ? total : '0;
        end
    end

    csds_ram #(
        .WIDTH (CYL_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (req.cylinder),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    csds_scan #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (close),
        .n       (n_close),
        .sched   (sched_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .emit    (emit)
    );

    assign busy         = busy_reg;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    // a closing transfer starts the schedule
    a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
        close |=> busy_reg)
        else $error("batch close did not raise busy");

    // results only come from a running batch
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> $past(busy_reg))
        else $error("result outside a batch");

    // nothing follows the final result of a batch
    a_last_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.last_served |=> !result_valid_reg)
        else $error("result after final result");
`endif

endmodule
